// ----- rtl/gamepad_event_to_report_core_defines.svh -----
// Assertion macros for the gamepad report block.
// Every property is sampled on clk_i and is off while rst_ni is low.
`ifndef GAMEPAD_EVENT_TO_REPORT_CORE_DEFINES_SVH
`define GAMEPAD_EVENT_TO_REPORT_CORE_DEFINES_SVH

`define GE2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// cons must hold in the cycle after ante
`define GE2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

// ----- rtl/ge2r_pkg.sv -----
package ge2r_pkg;

  localparam int unsigned PAD_SLOTS = 4;
  localparam int unsigned SLOT_AW   = (PAD_SLOTS > 1) ? $clog2(PAD_SLOTS) : 1;

  typedef enum logic [1:0] {
    KIND_PRESENCE = 2'd0,
    KIND_BUTTON   = 2'd1,
    KIND_AXIS     = 2'd2,
    KIND_NONE     = 2'd3
  } ev_kind_e;

  typedef enum logic [2:0] {
    AXIS_LT   = 3'd0,
    AXIS_RT   = 3'd1,
    AXIS_LX   = 3'd2,
    AXIS_LY   = 3'd3,
    AXIS_RX   = 3'd4,
    AXIS_RY   = 3'd5,
    AXIS_UNK6 = 3'd6,
    AXIS_UNK7 = 3'd7
  } axis_code_e;

  localparam logic [3:0] BTN_UNKNOWN = 4'd15;

  localparam logic REPORT_NOTICE = 1'b0;
  localparam logic REPORT_STATUS = 1'b1;

  // Slot record as it sits in the record RAM.
  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  ltrig;
    logic [7:0]  rtrig;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } pad_rec_t;

  localparam int unsigned REC_W = $bits(pad_rec_t);

endpackage

// ----- rtl/ge2r_ram.sv -----
module ge2r_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gamepad_event_to_report_core.sv -----
// Gamepad event to report core.
// Inputs and the record RAM read are registered on accept; any result is
// registered in ST_EXEC once the output can load. A new event is taken only
// in ST_IDLE, after the record RAM read and the write-back of the last slot.
// Reset: all slots absent; the record RAM is not cleared, since an attach
// rewrites a slot record before any report can read it.
module gamepad_event_to_report_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  pad_index_i,
  input  logic        on_flag_i,
  input  logic [3:0]  button_code_i,
  input  logic [2:0]  axis_code_i,
  input  logic signed [15:0] axis_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        report_kind_o,
  output logic [3:0]  slot_out_o,
  output logic        attached_o,
  output logic [15:0] button_mask_o,
  output logic [7:0]  left_trigger_out_o,
  output logic [7:0]  right_trigger_out_o,
  output logic signed [15:0] left_x_out_o,
  output logic signed [15:0] left_y_out_o,
  output logic signed [15:0] right_x_out_o,
  output logic signed [15:0] right_y_out_o
);
  import ge2r_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  function automatic logic [15:0] btn_bit(input logic [3:0] code);
    logic [15:0] b;
    unique case (code)
      4'd0:    b = 16'h1000;
      4'd1:    b = 16'h2000;
      4'd2:    b = 16'h4000;
      4'd3:    b = 16'h8000;
      4'd4:    b = 16'h0020;
      4'd6:    b = 16'h0010;
      4'd7:    b = 16'h0040;
      4'd8:    b = 16'h0080;
      4'd9:    b = 16'h0100;
      4'd10:   b = 16'h0200;
      4'd11:   b = 16'h0001;
      4'd12:   b = 16'h0002;
      4'd13:   b = 16'h0004;
      4'd14:   b = 16'h0008;
      default: b = 16'h0000; // guide and unknown
    endcase
    return b;
  endfunction

  // v * 255 / 32767: quotient by 2^15 plus one correction step, since
  // 32767 = 2^15 - 1 and the remainder estimate stays below 2 * 32767.
  function automatic logic [7:0] scale_trig(input logic signed [15:0] v);
    logic [22:0] p;
    logic [7:0]  q0;
    logic [15:0] r;
    logic [7:0]  q;
    p  = 23'(v[14:0]) * 23'd255;
    q0 = p[22:15];
    r  = {1'b0, p[14:0]} + {8'd0, q0};
    q  = (r >= 16'd32767) ? q0 + 8'd1 : q0;
    if (v[15]) begin
      q = 8'd0;
    end
    return q;
  endfunction

  function automatic logic [15:0] flip_y(input logic signed [15:0] v);
    logic [15:0] r;
    if (v == 16'sh8000) begin
      r = 16'h7FFF;
    end else begin
      r = 16'(-v);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [1:0]  kind_q;
  logic [3:0]  idx_q;
  logic        on_q;
  logic [3:0]  btn_q;
  logic [2:0]  axis_q;
  logic [15:0] val_q;

  logic [PAD_SLOTS-1:0] present_q, present_d;

  logic             in_fire;
  logic             can_load;
  logic             exec;
  logic [SLOT_AW-1:0] slot_addr;
  logic             in_range;
  logic             slot_on;
  logic [REC_W-1:0] rd_data;
  pad_rec_t         rec_rd, rec_wr;
  logic             we;
  logic             emit;
  logic             emit_kind;

  logic        out_valid_q;
  logic        rkind_q, attached_q;
  logic [3:0]  slot_q;
  pad_rec_t    out_rec_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_load   = !out_valid_q || out_ready_i;
  assign exec       = (state_q == ST_EXEC) && can_load;
  assign slot_addr  = idx_q[SLOT_AW-1:0];
  assign in_range   = ({1'b0, idx_q} < 5'(PAD_SLOTS));
  assign slot_on    = present_q[slot_addr];
  assign rec_rd     = pad_rec_t'(rd_data);

  ge2r_ram #(
    .Width (REC_W),
    .Depth (PAD_SLOTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot_addr),
    .wdata_i (REC_W'(rec_wr)),
    .re_i    (in_fire),
    .raddr_i (pad_index_i[SLOT_AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    rec_wr    = rec_rd;
    we        = 1'b0;
    emit      = 1'b0;
    emit_kind = REPORT_STATUS;
    present_d = present_q;
    if (exec && in_range) begin
      unique case (ev_kind_e'(kind_q))
        KIND_PRESENCE: begin
          emit      = 1'b1;
          emit_kind = REPORT_NOTICE;
          present_d[slot_addr] = on_q;
          if (on_q) begin
            we     = 1'b1;
            rec_wr = '0;
          end
        end
        KIND_BUTTON: begin
          if (slot_on && btn_q != BTN_UNKNOWN) begin
            we   = 1'b1;
            emit = 1'b1;
            if (on_q) begin
              rec_wr.buttons = rec_rd.buttons | btn_bit(btn_q);
            end else begin
              rec_wr.buttons = rec_rd.buttons & ~btn_bit(btn_q);
            end
          end
        end
        KIND_AXIS: begin
          if (slot_on) begin
            we   = 1'b1;
            emit = 1'b1;
            unique case (axis_code_e'(axis_q))
              AXIS_LT: rec_wr.ltrig = scale_trig(val_q);
              AXIS_RT: rec_wr.rtrig = scale_trig(val_q);
              AXIS_LX: rec_wr.lx    = val_q;
              AXIS_LY: rec_wr.ly    = flip_y(val_q);
              AXIS_RX: rec_wr.rx    = val_q;
              AXIS_RY: rec_wr.ry    = flip_y(val_q);
              default: begin
                we   = 1'b0;
                emit = 1'b0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (can_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      idx_q  <= pad_index_i;
      on_q   <= on_flag_i;
      btn_q  <= button_code_i;
      axis_q <= axis_code_i;
      val_q  <= axis_value_i;
    end
    if (emit) begin
      rkind_q <= emit_kind;
      slot_q  <= idx_q;
      if (emit_kind == REPORT_NOTICE) begin
        attached_q <= on_q;
        out_rec_q  <= '0;
      end else begin
        attached_q <= 1'b1;
        out_rec_q  <= rec_wr;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign report_kind_o       = rkind_q;
  assign slot_out_o          = slot_q;
  assign attached_o          = attached_q;
  assign button_mask_o       = out_rec_q.buttons;
  assign left_trigger_out_o  = out_rec_q.ltrig;
  assign right_trigger_out_o = out_rec_q.rtrig;
  assign left_x_out_o        = out_rec_q.lx;
  assign left_y_out_o        = out_rec_q.ly;
  assign right_x_out_o       = out_rec_q.rx;
  assign right_y_out_o       = out_rec_q.ry;

endmodule

// ----- rtl/ge2r_checker.sv -----
`include "gamepad_event_to_report_core_defines.svh"

module ge2r_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        report_kind_o,
  input logic [3:0]  slot_out_o,
  input logic        attached_o,
  input logic [15:0] button_mask_o,
  input logic [7:0]  left_trigger_out_o,
  input logic [7:0]  right_trigger_out_o,
  input logic [15:0] left_x_out_o,
  input logic [15:0] left_y_out_o,
  input logic [15:0] right_x_out_o,
  input logic [15:0] right_y_out_o
);
  import ge2r_pkg::*;

  logic notice_data_zero;
  logic status_shape_ok;

  assign notice_data_zero = (button_mask_o == 16'h0) && (left_trigger_out_o == 8'h0) &&
                            (right_trigger_out_o == 8'h0) && (left_x_out_o == 16'h0) &&
                            (left_y_out_o == 16'h0) && (right_x_out_o == 16'h0) &&
                            (right_y_out_o == 16'h0);
  assign status_shape_ok  = attached_o && (left_y_out_o != 16'h8000) &&
                            (right_y_out_o != 16'h8000) &&
                            ({1'b0, slot_out_o} < 5'(PAD_SLOTS));

  // one request in flight: the core is busy the cycle after it takes one
  `GE2R_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `GE2R_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(slot_out_o), "result dropped")
  `GE2R_ASSERT(a_notice_zero, out_valid_o && report_kind_o == REPORT_NOTICE |-> notice_data_zero, "notice with data")
  `GE2R_ASSERT(a_status_shape, out_valid_o && report_kind_o == REPORT_STATUS |-> status_shape_ok, "bad status report")

endmodule

bind gamepad_event_to_report_core ge2r_checker u_ge2r_checker (.*);

// ----- tb/gamepad_event_to_report_core_tb.sv -----
`timescale 1ns / 1ps

module gamepad_event_to_report_core_tb;
  import ge2r_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_EVENTS  = 1825;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_START     = 1500;
  localparam int HOLD_CYCLES    = 300;
  localparam int CALM_START     = 3000;
  localparam int CALM_END       = 4000;
  localparam int SEND_CALM_LO   = 700;
  localparam int SEND_CALM_HI   = 1100;
  localparam int MAX_PRINTED    = 40;

  localparam logic [15:0] VAL_MIN     = 16'h8000;
  localparam logic [15:0] VAL_MIN_P1  = 16'h8001;
  localparam logic [15:0] VAL_MAX     = 16'h7FFF;
  localparam logic [15:0] VAL_NEG_ONE = 16'hFFFF;
  localparam logic [15:0] VAL_ONE     = 16'h0001;
  localparam logic [15:0] VAL_ZERO    = 16'h0000;

  typedef enum logic [3:0] {
    PB_A, PB_B, PB_X, PB_Y, PB_BACK, PB_GUIDE, PB_START, PB_LSTICK, PB_RSTICK,
    PB_LSHOULDER, PB_RSHOULDER, PB_DUP, PB_DDOWN, PB_DLEFT, PB_DRIGHT
  } pad_button_e;

  // how a request's result is judged: by the predictor, typed in directly, or not expected at all
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_NOTICE} row_check_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [3:0]  pad;
    logic        on;
    logic [3:0]  btn;
    axis_code_e  axis;
    logic [15:0] val;
    row_check_e  check;
  } event_row_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic        attached;
    logic [15:0] mask;
    logic [7:0]  ltrig;
    logic [7:0]  rtrig;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } pad_report_t;

  localparam event_row_t DIRECTED_ROWS [25] = '{
    '{KIND_BUTTON,   4'd0,  1'b1, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NONE},
    '{KIND_PRESENCE, 4'd0,  1'b1, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NOTICE},
    '{KIND_PRESENCE, 4'd3,  1'b1, PB_B,        AXIS_RT,   VAL_MAX,     CHK_NOTICE},
    '{KIND_PRESENCE, 4'd4,  1'b1, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NONE},
    '{KIND_PRESENCE, 4'd15, 1'b1, BTN_UNKNOWN, AXIS_UNK7, VAL_NEG_ONE, CHK_NONE},
    '{KIND_BUTTON,   4'd0,  1'b1, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_PRED},
    '{KIND_BUTTON,   4'd0,  1'b1, PB_GUIDE,    AXIS_LT,   VAL_ZERO,    CHK_PRED},
    '{KIND_BUTTON,   4'd0,  1'b1, BTN_UNKNOWN, AXIS_LT,   VAL_ZERO,    CHK_NONE},
    '{KIND_BUTTON,   4'd3,  1'b1, PB_DRIGHT,   AXIS_LT,   VAL_ZERO,    CHK_PRED},
    '{KIND_BUTTON,   4'd0,  1'b0, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_LT,   VAL_MAX,     CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_LT,   VAL_MIN,     CHK_PRED},
    '{KIND_AXIS,     4'd3,  1'b0, PB_A,        AXIS_RT,   VAL_MAX,     CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_LX,   VAL_MIN,     CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_LY,   VAL_MIN,     CHK_PRED},
    '{KIND_AXIS,     4'd3,  1'b0, PB_A,        AXIS_LY,   VAL_MAX,     CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_RX,   VAL_MAX,     CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_RY,   VAL_MIN_P1,  CHK_PRED},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_UNK6, VAL_ONE,     CHK_NONE},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_UNK7, VAL_NEG_ONE, CHK_NONE},
    '{KIND_NONE,     4'd0,  1'b1, PB_A,        AXIS_LT,   VAL_MAX,     CHK_NONE},
    '{KIND_PRESENCE, 4'd0,  1'b0, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NOTICE},
    '{KIND_AXIS,     4'd0,  1'b0, PB_A,        AXIS_LT,   VAL_MAX,     CHK_NONE},
    '{KIND_PRESENCE, 4'd2,  1'b0, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NOTICE},
    '{KIND_PRESENCE, 4'd0,  1'b1, PB_A,        AXIS_LT,   VAL_ZERO,    CHK_NOTICE}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         kind_i;
  logic [3:0]         pad_index_i;
  logic               on_flag_i;
  logic [3:0]         button_code_i;
  logic [2:0]         axis_code_i;
  logic signed [15:0] axis_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               report_kind_o;
  logic [3:0]         slot_out_o;
  logic               attached_o;
  logic [15:0]        button_mask_o;
  logic [7:0]         left_trigger_out_o;
  logic [7:0]         right_trigger_out_o;
  logic signed [15:0] left_x_out_o;
  logic signed [15:0] left_y_out_o;
  logic signed [15:0] right_x_out_o;
  logic signed [15:0] right_y_out_o;

  row_check_e  row_check;
  pad_report_t expected_reports [$];
  logic        pad_live [16];
  pad_rec_t    pad_rec [16];
  int          cycle_count = 0;
  int          mismatches = 0;
  int          events_taken = 0;
  int          events_ignored = 0;
  int          reports_queued = 0;
  int          notices_seen = 0;
  int          status_seen = 0;
  bit          sender_gaps = 1'b1;

  gamepad_event_to_report_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .pad_index_i         (pad_index_i),
    .on_flag_i           (on_flag_i),
    .button_code_i       (button_code_i),
    .axis_code_i         (axis_code_i),
    .axis_value_i        (axis_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .report_kind_o       (report_kind_o),
    .slot_out_o          (slot_out_o),
    .attached_o          (attached_o),
    .button_mask_o       (button_mask_o),
    .left_trigger_out_o  (left_trigger_out_o),
    .right_trigger_out_o (right_trigger_out_o),
    .left_x_out_o        (left_x_out_o),
    .left_y_out_o        (left_y_out_o),
    .right_x_out_o       (right_x_out_o),
    .right_y_out_o       (right_y_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic logic [15:0] button_bit(input logic [3:0] btn);
    case (btn)
      PB_A:         return 16'h1000;
      PB_B:         return 16'h2000;
      PB_X:         return 16'h4000;
      PB_Y:         return 16'h8000;
      PB_BACK:      return 16'h0020;
      PB_START:     return 16'h0010;
      PB_LSTICK:    return 16'h0040;
      PB_RSTICK:    return 16'h0080;
      PB_LSHOULDER: return 16'h0100;
      PB_RSHOULDER: return 16'h0200;
      PB_DUP:       return 16'h0001;
      PB_DDOWN:     return 16'h0002;
      PB_DLEFT:     return 16'h0004;
      PB_DRIGHT:    return 16'h0008;
      default:      return 16'h0000;
    endcase
  endfunction

  function automatic logic [7:0] trigger_scale(input logic signed [15:0] val);
    int v;
    v = val;
    if (v < 0) return 8'd0;
    return 8'(v * 255 / 32767);
  endfunction

  function automatic logic [15:0] stick_y_flip(input logic signed [15:0] val);
    int v;
    v = val;
    if (v < -32767) v = -32767;
    return 16'(-v);
  endfunction

  // Applies one request to the shadow slot records; returns 1 when it yields a result.
  function automatic bit predict_report(input logic [1:0] kind, input logic [3:0] pad,
                                        input logic on, input logic [3:0] btn,
                                        input logic [2:0] axis,
                                        input logic signed [15:0] val,
                                        output pad_report_t rep);
    pad_rec_t r;
    bit       fired;
    fired = 1'b0;
    rep = '0;
    if (pad >= PAD_SLOTS) return 1'b0;
    r = pad_rec[pad];
    case (kind)
      KIND_PRESENCE: begin
        if (on) r = '0;
        pad_live[pad] = on;
        rep.kind = REPORT_NOTICE;
        rep.slot = pad;
        rep.attached = on;
        pad_rec[pad] = r;
        return 1'b1;
      end
      KIND_BUTTON: begin
        if (pad_live[pad] && btn != BTN_UNKNOWN) begin
          r.buttons = on ? (r.buttons | button_bit(btn)) : (r.buttons & ~button_bit(btn));
          fired = 1'b1;
        end
      end
      KIND_AXIS: begin
        if (pad_live[pad]) begin
          fired = 1'b1;
          case (axis)
            AXIS_LT: r.ltrig = trigger_scale(val);
            AXIS_RT: r.rtrig = trigger_scale(val);
            AXIS_LX: r.lx = val;
            AXIS_LY: r.ly = stick_y_flip(val);
            AXIS_RX: r.rx = val;
            AXIS_RY: r.ry = stick_y_flip(val);
            default: fired = 1'b0;
          endcase
        end
      end
      default: ;
    endcase
    if (fired) begin
      pad_rec[pad] = r;
      rep = '{REPORT_STATUS, pad, 1'b1, r.buttons, r.ltrig, r.rtrig, r.lx, r.ly, r.rx, r.ry};
    end
    return fired;
  endfunction

  always @(posedge clk_i) begin : event_capture
    pad_report_t rep;
    bit          fired;
    if (rst_ni && in_valid_i && in_ready_o) begin
      events_taken++;
      fired = predict_report(kind_i, pad_index_i, on_flag_i, button_code_i, axis_code_i,
                             axis_value_i, rep);
      if (!fired) events_ignored++;
      case (row_check)
        CHK_PRED: begin
          if (fired) begin
            expected_reports.push_back(rep);
            reports_queued++;
          end
        end
        CHK_NOTICE: begin
          rep = '0;
          rep.kind = REPORT_NOTICE;
          rep.slot = pad_index_i;
          rep.attached = on_flag_i;
          expected_reports.push_back(rep);
          reports_queued++;
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : report_check
    pad_report_t got;
    pad_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{report_kind_o, slot_out_o, attached_o, button_mask_o, left_trigger_out_o,
              right_trigger_out_o, left_x_out_o, left_y_out_o, right_x_out_o,
              right_y_out_o};
      if (got.kind == REPORT_NOTICE) notices_seen++;
      else status_seen++;
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("result for slot %0d with none pending", got.slot));
      end else begin
        want = expected_reports.pop_front();
        compare_field("report_kind", 16'(got.kind), 16'(want.kind));
        compare_field("slot_out", 16'(got.slot), 16'(want.slot));
        compare_field("attached", 16'(got.attached), 16'(want.attached));
        compare_field("button_mask", got.mask, want.mask);
        compare_field("left_trigger_out", 16'(got.ltrig), 16'(want.ltrig));
        compare_field("right_trigger_out", 16'(got.rtrig), 16'(want.rtrig));
        compare_field("left_x_out", got.lx, want.lx);
        compare_field("left_y_out", got.ly, want.ly);
        compare_field("right_x_out", got.rx, want.rx);
        compare_field("right_y_out", got.ry, want.ry);
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the block backs up, and a calm stretch.
  initial begin : report_sink
    int hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle_count == HOLD_START) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (cycle_count >= CALM_START && cycle_count < CALM_END) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic offer_event(input event_row_t ev);
    while (sender_gaps && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= ev.kind;
    pad_index_i   <= ev.pad;
    on_flag_i     <= ev.on;
    button_code_i <= ev.btn;
    axis_code_i   <= ev.axis;
    axis_value_i  <= ev.val;
    row_check     <= ev.check;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [15:0] random_axis_value();
    logic [15:0] corners [6];
    corners = '{VAL_MIN, VAL_MIN_P1, VAL_MAX, VAL_ZERO, VAL_NEG_ONE, VAL_ONE};
    if ($urandom_range(0, 9) < 3) return corners[$urandom_range(0, 5)];
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    event_row_t ev;
    int         pick;
    int         sent;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_PRESENCE;
    pad_index_i   = '0;
    on_flag_i     = 1'b0;
    button_code_i = '0;
    axis_code_i   = AXIS_LT;
    axis_value_i  = '0;
    row_check     = CHK_PRED;
    for (int i = 0; i < 16; i++) begin
      pad_live[i] = 1'b0;
      pad_rec[i]  = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) offer_event(DIRECTED_ROWS[i]);

    // Mostly events on in-range slots; out-of-range pads, unknown codes and stray kinds mixed in.
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      sender_gaps = !(sent >= SEND_CALM_LO && sent < SEND_CALM_HI);
      ev.pad   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(PAD_SLOTS, 15))
                                             : 4'($urandom_range(0, PAD_SLOTS - 1));
      ev.on    = 1'($urandom);
      ev.btn   = 4'($urandom);
      ev.axis  = axis_code_e'($urandom_range(0, 7));
      ev.val   = random_axis_value();
      ev.check = CHK_PRED;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        ev.kind = KIND_PRESENCE;
        ev.on   = (pick < 8);
      end else if (pick < 55) begin
        ev.kind = KIND_BUTTON;
        ev.btn  = ($urandom_range(0, 19) == 0) ? BTN_UNKNOWN : 4'($urandom_range(0, 14));
      end else if (pick < 97) begin
        ev.kind = KIND_AXIS;
        ev.axis = ($urandom_range(0, 15) == 0) ? axis_code_e'($urandom_range(6, 7))
                                               : axis_code_e'($urandom_range(0, 5));
      end else begin
        ev.kind = KIND_NONE;
      end
      offer_event(ev);
      sent++;
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests (%0d ignored, %0d results expected).",
             events_taken, events_ignored, reports_queued);
    $display("Saw %0d notices, %0d status reports; output held off %0d cycles once; %0d mismatches.",
             notices_seen, status_seen, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
